FILE: hw/rtl/channel_volume_fade_ramp_assert.svh
// Assertion macros shared by the fade ramp block
`ifndef CHANNEL_VOLUME_FADE_RAMP_ASSERT_SVH
`define CHANNEL_VOLUME_FADE_RAMP_ASSERT_SVH

// Same-cycle implication
`define CVFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CVFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cvfr_pkg.sv
package cvfr_pkg;

  typedef enum logic [1:0] {
    OP_SET_SPEED  = 2'd0,
    OP_START_FADE = 2'd1,
    OP_FADE_STEP  = 2'd2,
    OP_SET_LEVEL  = 2'd3
  } cvfr_op_t;

  localparam int DIV_W     = 41;
  localparam int DIVISOR_W = 25;
  localparam int STEP_W    = 24;
  localparam int SCALE_W   = 33;
  localparam int ITER_W    = 6;

  localparam logic [ITER_W-1:0] STEP_ITERS  = 6'd24;
  localparam logic [ITER_W-1:0] SCALE_ITERS = 6'd41;

  localparam logic [7:0]  DEFAULT_SPEED = 8'h88;
  localparam int          DOUBLE_UP_BIT = 7;
  localparam logic [22:0] TICK_MUL      = 23'd100;
  localparam logic [15:0] TICK_RESET    = 16'd1000;
  localparam logic [31:0] DELAY_SAT     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic decode;
    logic div_step;
    logic commit_step;
    logic step;
    logic div_scale;
    logic take_scale;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic emit;
  } cvfr_ctl_t;

  typedef struct packed {
    logic     in_range;
    cvfr_op_t op;
    logic     retarget;
    logic     was_idle;
    logic     div_done;
    logic     step_end;
    logic     step_inf;
    logic     step_direct;
  } cvfr_sts_t;

endpackage

FILE: hw/rtl/channel_volume_fade_ramp.sv
// Channel  | Handshake                         | Beat
// ---------+-----------------------------------+------------------------------------
// item in  | start & !busy                     | cmd, channel, level
// result   | done (one cycle, no backpressure) | out_channel, current_level,
//          |                                   | reschedule, next_delay, active_mask
// config   | psel & penable & pwrite & pready  | paddr, pwdata (tick_period)
//
// Set speed, set level and no-op starts go from decode straight to finish. A retarget
// runs a serial step divide, and a retarget of an idle channel then steps. A step that
// neither reaches its target nor saturates runs a scale divide (skipped for a direct step),
// then the multiply-low, multiply-high and sum states. The divider is shared. busy drops with done.
// rst is synchronous and clears all channel state; tick_period resets to 1000.
module channel_volume_fade_ramp #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [3:0]  channel,
  input  logic [7:0]  level,
  output logic        done,
  output logic [3:0]  out_channel,
  output logic [7:0]  current_level,
  output logic        reschedule,
  output logic [31:0] next_delay,
  output logic [15:0] active_mask,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cvfr_pkg::*;

  logic [15:0] tick_period;
  logic        cfg_wr;
  cvfr_ctl_t   ctl;
  cvfr_sts_t   sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == 2'd0) ? {16'd0, tick_period} : {16'd0, tick_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_RESET;
    end else if (cfg_wr) begin
      tick_period <= pwdata[15:0];
    end
  end

  cvfr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  cvfr_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .capture       (start && !busy),
    .cmd_in        (cmd),
    .channel_in    (channel),
    .level_in      (level),
    .tick_period   (tick_period),
    .ctl           (ctl),
    .sts           (sts),
    .out_channel   (out_channel),
    .current_level (current_level),
    .reschedule    (reschedule),
    .next_delay    (next_delay),
    .active_mask   (active_mask)
  );

`include "channel_volume_fade_ramp_assert.svh"

  `CVFR_ASSERT_NOW(a_done_idle, done, !busy, "result beat while busy")
  `CVFR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not start work")
  `CVFR_ASSERT_NOW(a_delay_zero, done && !reschedule, next_delay == 32'd0,
    "delay without reschedule")
  `CVFR_ASSERT_NEXT(a_single_done, done, !done, "double result beat")

endmodule

FILE: hw/rtl/cvfr_div.sv
module cvfr_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cvfr_pkg::DIV_W-1:0]     dividend,
  input  logic [cvfr_pkg::DIVISOR_W-1:0] divisor,
  input  logic [cvfr_pkg::ITER_W-1:0]    iters,
  output logic                           done,
  output logic [cvfr_pkg::DIV_W-1:0]     quotient
);
  import cvfr_pkg::*;

  logic                 running;
  logic [ITER_W-1:0]    cnt;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] rem;
  logic [DIV_W-1:0]     dq;
  logic [DIVISOR_W:0]   trial;
  logic                 ge;

  assign trial    = {rem, dq[DIV_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= iters;
        dvs     <= divisor;
        rem     <= '0;
        dq      <= dividend;
      end else if (running) begin
        rem <= ge ? DIVISOR_W'(trial - {1'b0, dvs}) : trial[DIVISOR_W-1:0];
        dq  <= {dq[DIV_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == ITER_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/cvfr_datapath.sv
module cvfr_datapath #(
  parameter int CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                capture,
  input  logic [1:0]          cmd_in,
  input  logic [3:0]          channel_in,
  input  logic [7:0]          level_in,
  input  logic [15:0]         tick_period,
  input  cvfr_pkg::cvfr_ctl_t ctl,
  output cvfr_pkg::cvfr_sts_t sts,
  output logic [3:0]          out_channel,
  output logic [7:0]          current_level,
  output logic                reschedule,
  output logic [31:0]         next_delay,
  output logic [15:0]         active_mask
);
  import cvfr_pkg::*;

  localparam int         IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

  logic [7:0]        fade_level  [CHANNELS];
  logic [7:0]        fade_target [CHANNELS];
  logic [STEP_W-1:0] fade_step   [CHANNELS];
  logic [7:0]        fade_speed  [CHANNELS];
  logic [15:0]       channel_mask;

  logic [3:0]  ch_q;
  cvfr_op_t    op_q;
  logic [7:0]  lv_q;
  logic        was_idle;
  logic        again;
  logic [31:0] delay;
  logic [SCALE_W-1:0] scale;
  logic [39:0] p_lo;
  logic [38:0] p_hi;

  logic [IDX_W-1:0] idx;
  logic        in_range;
  logic [7:0]  cur, tgt, spd, spd_eff;
  logic [6:0]  dur;
  logic [7:0]  sdiff;
  logic        up;
  logic [DIVISOR_W-1:0] s25;
  logic [8:0]  n, n_eff, diff9, mv;
  logic [7:0]  newcur;
  logic        div_start, div_done;
  logic [DIV_W-1:0]     div_dividend, quot;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [ITER_W-1:0]    div_iters;
  logic [22:0] tp100;
  logic [56:0] sum;

  assign idx      = ch_q[IDX_W-1:0];
  assign in_range = {1'b0, ch_q} < CH_LIMIT;
  assign cur      = fade_level[idx];
  assign tgt      = fade_target[idx];
  assign spd      = fade_speed[idx];
  assign spd_eff  = (spd == 8'd0) ? DEFAULT_SPEED : spd;
  assign dur      = (spd_eff[6:0] == 7'd0) ? 7'd1 : spd_eff[6:0];
  assign sdiff    = (lv_q > cur) ? lv_q - cur : cur - lv_q;

  assign up     = tgt > cur;
  assign s25    = (up && spd[DOUBLE_UP_BIT]) ? {fade_step[idx], 1'b0}
                                             : {1'b0, fade_step[idx]};
  assign n      = s25[DIVISOR_W-1:16];
  assign n_eff  = (n == 9'd0) ? 9'd1 : n;
  assign diff9  = {1'b0, up ? tgt - cur : cur - tgt};
  assign mv     = (diff9 > n_eff) ? n_eff : diff9;
  assign newcur = up ? cur + mv[7:0] : cur - mv[7:0];

  assign sts.in_range    = in_range;
  assign sts.op          = op_q;
  assign sts.retarget    = tgt != lv_q;
  assign sts.was_idle    = was_idle;
  assign sts.div_done    = div_done;
  assign sts.step_end    = newcur == tgt;
  assign sts.step_inf    = up && (s25 == '0);
  assign sts.step_direct = !up && (n == 9'd0);

  assign div_start    = ctl.div_step | ctl.div_scale;
  assign div_dividend = ctl.div_step ? {sdiff, 33'd0} : {n_eff, 32'd0};
  assign div_divisor  = ctl.div_step ? {18'd0, dur} : s25;
  assign div_iters    = ctl.div_step ? STEP_ITERS : SCALE_ITERS;

  cvfr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (quot)
  );

  assign tp100 = 23'(tick_period) * TICK_MUL;
  assign sum   = {1'b0, p_hi, 17'd0} + 57'(p_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fade_level[i]  <= '0;
        fade_target[i] <= '0;
        fade_step[i]   <= '0;
        fade_speed[i]  <= '0;
      end
      channel_mask <= '0;
    end else begin
      if (capture) begin
        ch_q <= channel_in;
        op_q <= cvfr_op_t'(cmd_in);
        lv_q <= level_in;
      end
      if (ctl.decode) begin
        again    <= 1'b0;
        delay    <= '0;
        was_idle <= tgt == cur;
        if (in_range) begin
          unique case (op_q)
            OP_SET_SPEED: fade_speed[idx] <= lv_q;
            OP_START_FADE: begin
              if (spd == 8'd0) fade_speed[idx] <= DEFAULT_SPEED;
            end
            OP_SET_LEVEL: begin
              fade_level[idx]    <= lv_q;
              fade_target[idx]   <= lv_q;
              channel_mask[ch_q] <= lv_q != 8'd0;
            end
            default: ;
          endcase
        end
      end
      if (ctl.commit_step) begin
        fade_step[idx]   <= quot[STEP_W-1:0];
        fade_target[idx] <= lv_q;
      end
      if (ctl.step) begin
        fade_level[idx]    <= newcur;
        channel_mask[ch_q] <= newcur != 8'd0;
        again              <= newcur != tgt;
        scale              <= SCALE_W'(s25);
        if (sts.step_inf) delay <= DELAY_SAT;
      end
      if (ctl.take_scale) scale <= quot[SCALE_W-1:0];
      if (ctl.mul_lo) p_lo <= 40'(tp100) * 40'(scale[16:0]);
      if (ctl.mul_hi) p_hi <= 39'(tp100) * 39'(scale[SCALE_W-1:17]);
      if (ctl.sum) delay <= (|sum[56:48]) ? DELAY_SAT : sum[47:16];
      if (ctl.emit) begin
        out_channel   <= ch_q;
        current_level <= in_range ? cur : 8'd0;
        reschedule    <= again;
        next_delay    <= again ? delay : 32'd0;
        active_mask   <= channel_mask;
      end
    end
  end

endmodule

FILE: hw/rtl/cvfr_ctrl.sv
module cvfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cvfr_pkg::cvfr_sts_t sts,
  output cvfr_pkg::cvfr_ctl_t ctl,
  output logic                busy,
  output logic                done
);
  import cvfr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DIV_STEP, S_STEP, S_DIV_SCALE,
    S_MUL_LO, S_MUL_HI, S_SUM, S_FINISH
  } state_t;

  state_t state, state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_DECODE;
      S_DECODE: begin
        ctl.decode = 1'b1;
        state_next = S_FINISH;
        if (sts.in_range) begin
          if (sts.op == OP_FADE_STEP) begin
            state_next = S_STEP;
          end else if (sts.op == OP_START_FADE && sts.retarget) begin
            ctl.div_step = 1'b1;
            state_next   = S_DIV_STEP;
          end
        end
      end
      S_DIV_STEP: begin
        if (sts.div_done) begin
          ctl.commit_step = 1'b1;
          state_next      = sts.was_idle ? S_STEP : S_FINISH;
        end
      end
      S_STEP: begin
        ctl.step = 1'b1;
        priority if (sts.step_end || sts.step_inf) begin
          state_next = S_FINISH;
        end else if (sts.step_direct) begin
          state_next = S_MUL_LO;
        end else begin
          ctl.div_scale = 1'b1;
          state_next    = S_DIV_SCALE;
        end
      end
      S_DIV_SCALE: begin
        if (sts.div_done) begin
          ctl.take_scale = 1'b1;
          state_next     = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        ctl.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        ctl.mul_hi = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        ctl.sum    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctl.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == S_FINISH;
    end
  end

endmodule
